### hdl/connection_slot_table_defines.svh
// ----------------------------------------------------------------------------
// connection_slot_table_defines.svh
// Assertion macros for the connection slot table checks.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_SLOT_TABLE_DEFINES_SVH
`define CONNECTION_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Types and constants shared by the connection slot table modules.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int CLIENT_W  = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_TIMEOUT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 32'd60000;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd15000;

    typedef enum logic [1:0] {
        OP_ADMIT      = 2'd0,
        OP_CONNECT    = 2'd1,
        OP_DISCONNECT = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

### hdl/cst_if.sv
// ----------------------------------------------------------------------------
// cst_if
// Request and response channels of the connection slot table.
// ----------------------------------------------------------------------------
interface cst_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [cst_pkg::CLIENT_W-1:0]  client_id;
    logic [cst_pkg::TIME_W-1:0]    now;

    modport source (output valid, output operation, output client_id, output now,
                    input ready);
    modport sink   (input valid, input operation, input client_id, input now,
                    output ready);
endinterface

interface cst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          admitted;
    logic [1:0]                    slot_index;
    logic                          found;
    logic                          evicted_valid;
    logic [cst_pkg::CLIENT_W-1:0]  evicted_client;
    logic [3:0]                    timeout_mask;
    logic                          heartbeat_sent;
    logic [31:0]                   message_number;
    logic [2:0]                    active_count;

    modport source (output valid, output admitted, output slot_index, output found,
                    output evicted_valid, output evicted_client, output timeout_mask,
                    output heartbeat_sent, output message_number, output active_count,
                    input ready);
    modport sink   (input valid, input admitted, input slot_index, input found,
                    input evicted_valid, input evicted_client, input timeout_mask,
                    input heartbeat_sent, input message_number, input active_count,
                    output ready);
endinterface

### hdl/cst_ctrl.sv
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer: accept, scan the slots, drain the last slot, post the result.
// ----------------------------------------------------------------------------
module cst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cst_pkg::status_t  status,
    output cst_pkg::cmd_t     cmd
);

    cst_pkg::state_t state_reg;
    cst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cst_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = cst_pkg::ST_SCAN;
                end
            end
            cst_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = cst_pkg::ST_DRAIN;
                end
            end
            cst_pkg::ST_DRAIN:
            begin
                state_next = cst_pkg::ST_FINISH;
            end
            cst_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            cst_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            cst_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            cst_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/cst_datapath.sv
// ----------------------------------------------------------------------------
// cst_datapath
// Slot stores, scan trackers, heartbeat state and the result register.
// ----------------------------------------------------------------------------
module cst_datapath #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cst_pkg::cmd_t                      cmd,
    output cst_pkg::status_t                   status,
    input  logic [1:0]                         operation,
    input  logic [cst_pkg::CLIENT_W-1:0]       client_id,
    input  logic [cst_pkg::TIME_W-1:0]         now,
    input  logic                               cfg_we,
    input  logic [cst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cst_pkg::CFG_W-1:0]          cfg_data,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic                               admitted,
    output logic [1:0]                         slot_index,
    output logic                               found,
    output logic                               evicted_valid,
    output logic [cst_pkg::CLIENT_W-1:0]       evicted_client,
    output logic [3:0]                         timeout_mask,
    output logic                               heartbeat_sent,
    output logic [31:0]                        message_number,
    output logic [2:0]                         active_count
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W+1:0]   MASK_LIM = (IDX_W + 2)'(4);

    // slot stores
    logic [cst_pkg::CLIENT_W-1:0]  client_mem [SLOT_COUNT];
    logic [cst_pkg::TIME_W-1:0]    conn_mem   [SLOT_COUNT];
    logic [cst_pkg::TIME_W-1:0]    last_mem   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]         valid_reg;
    logic [CNT_W-1:0]              cnt_reg;

    logic [cst_pkg::CLIENT_W-1:0]  rd_client_reg;
    logic [cst_pkg::TIME_W-1:0]    rd_conn_reg;
    logic [cst_pkg::TIME_W-1:0]    rd_last_reg;

    // captured transaction
    cst_pkg::op_t                  op_reg;
    logic [cst_pkg::CLIENT_W-1:0]  cid_reg;
    logic [cst_pkg::TIME_W-1:0]    now_reg;
    logic                          hb_due_reg;

    logic [cst_pkg::CFG_W-1:0]     timeout_reg;
    logic [cst_pkg::CFG_W-1:0]     interval_reg;
    logic [cst_pkg::TIME_W-1:0]    last_hb_reg;
    logic [31:0]                   msg_cnt_reg;

    // scan pipeline and trackers
    logic [IDX_W-1:0]              scan_idx_reg;
    logic                          eval_en_reg;
    logic [IDX_W-1:0]              eval_idx_reg;
    logic                          free_found_reg;
    logic [IDX_W-1:0]              free_idx_reg;
    logic [IDX_W-1:0]              min_idx_reg;
    logic [cst_pkg::TIME_W-1:0]    min_conn_reg;
    logic [cst_pkg::CLIENT_W-1:0]  min_client_reg;
    logic                          match_found_reg;
    logic [IDX_W-1:0]              match_idx_reg;
    logic [3:0]                    mask_reg;

    // result register
    logic                          rsp_valid_reg;
    logic                          admitted_reg;
    logic [1:0]                    slot_index_reg;
    logic                          found_reg;
    logic                          evicted_valid_reg;
    logic [cst_pkg::CLIENT_W-1:0]  evicted_client_reg;
    logic [3:0]                    timeout_mask_reg;
    logic                          heartbeat_sent_reg;
    logic [31:0]                   message_number_reg;
    logic [2:0]                    active_count_reg;

    logic                          eval_slot_valid;
    logic [cst_pkg::TIME_W-1:0]    idle_time;
    logic                          timed_out;
    logic                          id_match;
    logic [IDX_W+1:0]              eval_idx_ext;
    logic                          is_connect;
    logic                          is_tick;
    logic [IDX_W-1:0]              target_idx;
    logic                          commit_wr;
    logic                          refresh_wr;
    logic                          last_we;
    logic [IDX_W-1:0]              last_wr_idx;
    logic                          hb_send;
    logic [CNT_W-1:0]              cnt_after;
    logic [CNT_W+2:0]              cnt_after_ext;
    logic [IDX_W-1:0]              rsp_idx;
    logic [IDX_W+1:0]              rsp_idx_ext;

    assign eval_slot_valid = valid_reg[eval_idx_reg];
    assign idle_time       = now_reg - rd_last_reg;
    assign timed_out       = eval_slot_valid && (idle_time >= timeout_reg);
    assign id_match        = eval_slot_valid && (rd_client_reg == cid_reg);
    assign eval_idx_ext    = {2'b00, eval_idx_reg};

    assign is_connect  = (op_reg == cst_pkg::OP_CONNECT);
    assign is_tick     = (op_reg == cst_pkg::OP_TICK);
    assign target_idx  = free_found_reg ? free_idx_reg : min_idx_reg;
    assign commit_wr   = cmd.finish && is_connect;
    assign refresh_wr  = eval_en_reg && is_tick && hb_due_reg;
    assign last_we     = commit_wr || refresh_wr;
    assign last_wr_idx = commit_wr ? target_idx : eval_idx_reg;

    assign hb_send       = is_tick && hb_due_reg && (cnt_reg != '0);
    assign cnt_after     = cnt_reg + CNT_W'(is_connect && free_found_reg);
    assign cnt_after_ext = {3'b000, cnt_after};

    always_comb
    begin
        rsp_idx = '0;
        case (op_reg)
            cst_pkg::OP_CONNECT:
            begin
                rsp_idx = target_idx;
            end
            cst_pkg::OP_DISCONNECT:
            begin
                rsp_idx = match_found_reg ? match_idx_reg : '0;
            end
            default:
            begin
                rsp_idx = '0;
            end
        endcase
    end

    assign rsp_idx_ext = {2'b00, rsp_idx};

    assign status.scan_last = (scan_idx_reg == LAST_IDX);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    // slot memories, registered read at the scan pointer
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_client_reg <= client_mem[scan_idx_reg];
            rd_conn_reg   <= conn_mem[scan_idx_reg];
            rd_last_reg   <= last_mem[scan_idx_reg];
        end
        if (commit_wr)
        begin
            client_mem[target_idx] <= cid_reg;
            conn_mem[target_idx]   <= now_reg;
        end
        if (last_we)
        begin
            last_mem[last_wr_idx] <= now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= cst_pkg::TIMEOUT_RESET;
            interval_reg    <= cst_pkg::INTERVAL_RESET;
            valid_reg       <= '0;
            cnt_reg         <= '0;
            last_hb_reg     <= '0;
            msg_cnt_reg     <= '0;
            op_reg          <= cst_pkg::OP_ADMIT;
            hb_due_reg      <= 1'b0;
            scan_idx_reg    <= '0;
            eval_en_reg     <= 1'b0;
            eval_idx_reg    <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            min_idx_reg     <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            mask_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cst_pkg::CFG_CLIENT_TIMEOUT:     timeout_reg  <= cfg_data;
                    cst_pkg::CFG_HEARTBEAT_INTERVAL: interval_reg <= cfg_data;
                    default:                         timeout_reg  <= timeout_reg;
                endcase
            end

            if (cmd.load)
            begin
                op_reg          <= cst_pkg::op_t'(operation);
                hb_due_reg      <= ((now - last_hb_reg) >= interval_reg);
                scan_idx_reg    <= '0;
                free_found_reg  <= 1'b0;
                match_found_reg <= 1'b0;
                mask_reg        <= '0;
            end

            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            eval_en_reg  <= cmd.scan;
            eval_idx_reg <= scan_idx_reg;

            if (eval_en_reg)
            begin
                case (op_reg)
                    cst_pkg::OP_CONNECT:
                    begin
                        if (!free_found_reg && !eval_slot_valid)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= eval_idx_reg;
                        end
                        if ((eval_idx_reg == '0) || (rd_conn_reg < min_conn_reg))
                        begin
                            min_idx_reg <= eval_idx_reg;
                        end
                    end
                    cst_pkg::OP_DISCONNECT:
                    begin
                        if (!match_found_reg && id_match)
                        begin
                            match_found_reg         <= 1'b1;
                            match_idx_reg           <= eval_idx_reg;
                            valid_reg[eval_idx_reg] <= 1'b0;
                            cnt_reg                 <= cnt_reg - CNT_W'(1);
                        end
                    end
                    cst_pkg::OP_TICK:
                    begin
                        if (timed_out)
                        begin
                            valid_reg[eval_idx_reg] <= 1'b0;
                            cnt_reg                 <= cnt_reg - CNT_W'(1);
                            if (eval_idx_ext < MASK_LIM)
                            begin
                                mask_reg[eval_idx_ext[1:0]] <= 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        mask_reg <= mask_reg;
                    end
                endcase
            end

            if (cmd.finish)
            begin
                if (is_connect)
                begin
                    valid_reg[target_idx] <= 1'b1;
                    cnt_reg               <= cnt_after;
                end
                if (is_tick && hb_due_reg)
                begin
                    last_hb_reg <= now_reg;
                end
                if (hb_send)
                begin
                    msg_cnt_reg <= msg_cnt_reg + 32'd1;
                end
            end

            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload-only registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cid_reg <= client_id;
            now_reg <= now;
        end
        if (eval_en_reg && is_connect &&
            ((eval_idx_reg == '0) || (rd_conn_reg < min_conn_reg)))
        begin
            min_conn_reg   <= rd_conn_reg;
            min_client_reg <= rd_client_reg;
        end
        if (cmd.finish)
        begin
            admitted_reg       <= (op_reg == cst_pkg::OP_ADMIT) && (cnt_reg < FULL_CNT);
            slot_index_reg     <= rsp_idx_ext[1:0];
            found_reg          <= is_connect ||
                                  ((op_reg == cst_pkg::OP_DISCONNECT) && match_found_reg);
            evicted_valid_reg  <= is_connect && !free_found_reg;
            evicted_client_reg <= (is_connect && !free_found_reg) ? min_client_reg : '0;
            timeout_mask_reg   <= is_tick ? mask_reg : 4'd0;
            heartbeat_sent_reg <= hb_send;
            message_number_reg <= hb_send ? msg_cnt_reg : 32'd0;
            active_count_reg   <= cnt_after_ext[2:0];
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign admitted       = admitted_reg;
    assign slot_index     = slot_index_reg;
    assign found          = found_reg;
    assign evicted_valid  = evicted_valid_reg;
    assign evicted_client = evicted_client_reg;
    assign timeout_mask   = timeout_mask_reg;
    assign heartbeat_sent = heartbeat_sent_reg;
    assign message_number = message_number_reg;
    assign active_count   = active_count_reg;

endmodule

### hdl/connection_slot_table.sv
// ----------------------------------------------------------------------------
// connection_slot_table
// Fixed client slot table with oldest-connect eviction, idle timeout and
// numbered heartbeats.
//
//   channel    role    transaction
//   req        sink    operation, client_id, now
//   rsp        source  admitted .. active_count, one per request
//   cfg_*      sink    write of the idle timeout / heartbeat interval
//
// A request passes from acceptance to the next ready through the accept state,
// a scan of one slot per cycle through the single read port of the slot
// stores, a drain and a result state.
// The result register lets a new request in while the last result waits;
// a request that reaches its result cycle with the register still occupied
// holds there until rsp drains.
// Reset clears the valid bits, counters and heartbeat time; slot stores
// are not cleared.
// ----------------------------------------------------------------------------
module connection_slot_table #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cst_req_if.sink                        req,
    cst_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [cst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cst_pkg::CFG_W-1:0]      cfg_data
);

    cst_pkg::cmd_t    cmd;
    cst_pkg::status_t status;

    cst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cst_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (req.operation),
        .client_id      (req.client_id),
        .now            (req.now),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .admitted       (rsp.admitted),
        .slot_index     (rsp.slot_index),
        .found          (rsp.found),
        .evicted_valid  (rsp.evicted_valid),
        .evicted_client (rsp.evicted_client),
        .timeout_mask   (rsp.timeout_mask),
        .heartbeat_sent (rsp.heartbeat_sent),
        .message_number (rsp.message_number),
        .active_count   (rsp.active_count)
    );

endmodule

### hdl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the connection slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "connection_slot_table_defines.svh"

module cst_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic        rsp_admitted,
    input  logic [1:0]  rsp_slot_index,
    input  logic        rsp_found,
    input  logic        rsp_evicted_valid,
    input  logic [15:0] rsp_evicted_client,
    input  logic [3:0]  rsp_timeout_mask,
    input  logic        rsp_heartbeat_sent,
    input  logic [31:0] rsp_message_number
);

    // one transaction in flight: busy right after acceptance
    `CST_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

    `CST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_slot_index) && $stable(rsp_evicted_client) && $stable(rsp_message_number), "stalled response changed")

    // eviction only comes from a successful connect
    `CST_ASSERT_SAME(a_evict_connect, rsp_valid && rsp_evicted_valid, rsp_found && !rsp_admitted && rsp_timeout_mask == 4'd0 && !rsp_heartbeat_sent, "eviction outside connect")

    `CST_ASSERT_SAME(a_msg_zero, rsp_valid && !rsp_heartbeat_sent, rsp_message_number == 32'd0, "message number without heartbeat")

endmodule

bind connection_slot_table cst_checker u_cst_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_admitted       (rsp.admitted),
    .rsp_slot_index     (rsp.slot_index),
    .rsp_found          (rsp.found),
    .rsp_evicted_valid  (rsp.evicted_valid),
    .rsp_evicted_client (rsp.evicted_client),
    .rsp_timeout_mask   (rsp.timeout_mask),
    .rsp_heartbeat_sent (rsp.heartbeat_sent),
    .rsp_message_number (rsp.message_number)
);

### dv/tb_connection_slot_table.sv
// ----------------------------------------------------------------------------
// tb_connection_slot_table
// Self-checking bench for the connection slot table. A directed table covers
// the empty and full table, eviction, unmatched disconnects, timeouts and
// heartbeats across time wrap; random phases then run well-formed client
// traffic under several timeout and interval settings, with random idling on
// both channels and one long response stall. Every response is compared with
// a directed expectation or an in-bench model of the table.
// ----------------------------------------------------------------------------
module tb_connection_slot_table;

    localparam int SLOTS          = 4;
    localparam int DRAIN_CYCLES   = SLOTS + 3;
    localparam int STALL_CYCLES   = 300;
    localparam int IDLE_LIMIT     = 4000;
    localparam int PHASE_ITEMS    = 100;
    localparam int POOL_SIZE      = 6;

    typedef struct packed {
        logic        admitted;
        logic [1:0]  slot_index;
        logic        found;
        logic        evicted_valid;
        logic [15:0] evicted_client;
        logic [3:0]  timeout_mask;
        logic        heartbeat_sent;
        logic [31:0] message_number;
        logic [2:0]  active_count;
    } slot_result_t;

    typedef struct {
        cst_pkg::op_t op;
        logic [15:0]  cid;
        logic [31:0]  stamp;
        bit           typed;
        slot_result_t want;
    } dir_row_t;

    typedef struct {
        logic [31:0] timeout_ms;
        logic [31:0] interval_ms;
        int unsigned step_ms;
        bit          quiet;
    } phase_t;

    localparam slot_result_t PREDICT = '0;

    logic clk;
    logic rst_n;
    logic                          cfg_we;
    logic [cst_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cst_pkg::CFG_W-1:0]     cfg_data;

    cst_req_if req_ch ();
    cst_rsp_if rsp_ch ();

    connection_slot_table #(
        .SLOT_COUNT (SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state
    logic        slot_busy   [SLOTS];
    logic [15:0] slot_owner  [SLOTS];
    logic [31:0] slot_joined [SLOTS];
    logic [31:0] slot_seen   [SLOTS];
    logic [31:0] last_beat;
    logic [31:0] beat_seq;
    logic [31:0] timeout_ms;
    logic [31:0] beat_ms;

    slot_result_t pending_results [$];
    int           mismatch_count;
    bit           quiet;
    bit           hold_request;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int count_active();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i])
                n++;
        return n;
    endfunction

    function automatic slot_result_t slot_table_step(cst_pkg::op_t op, logic [15:0] cid,
                                                     logic [31:0] stamp);
        slot_result_t r;
        int           target;
        logic [31:0]  idle;
        r = '0;
        case (op)
            cst_pkg::OP_ADMIT:
            begin
                r.admitted = (count_active() < SLOTS);
            end
            cst_pkg::OP_CONNECT:
            begin
                target = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_busy[i] && target < 0)
                        target = i;
                if (target < 0)
                begin
                    target = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (slot_joined[i] < slot_joined[target])
                            target = i;
                    r.evicted_valid  = 1'b1;
                    r.evicted_client = slot_owner[target];
                end
                slot_busy[target]   = 1'b1;
                slot_owner[target]  = cid;
                slot_joined[target] = stamp;
                slot_seen[target]   = stamp;
                r.slot_index        = target[1:0];
                r.found             = 1'b1;
            end
            cst_pkg::OP_DISCONNECT:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!r.found && slot_busy[i] && slot_owner[i] == cid)
                    begin
                        slot_busy[i] = 1'b0;
                        r.slot_index = i[1:0];
                        r.found      = 1'b1;
                    end
                end
            end
            cst_pkg::OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    idle = stamp - slot_seen[i];
                    if (slot_busy[i] && idle >= timeout_ms)
                    begin
                        slot_busy[i] = 1'b0;
                        if (i < 4)
                            r.timeout_mask[i] = 1'b1;
                    end
                end
                idle = stamp - last_beat;
                if (idle >= beat_ms)
                begin
                    last_beat = stamp;
                    if (count_active() > 0)
                    begin
                        r.heartbeat_sent = 1'b1;
                        r.message_number = beat_seq;
                        beat_seq         = beat_seq + 32'd1;
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_busy[i])
                                slot_seen[i] = stamp;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.active_count = 3'(count_active());
        return r;
    endfunction

    function automatic slot_result_t res(int unsigned adm, int unsigned idx,
                                         int unsigned fnd, int unsigned evv,
                                         int unsigned evc, int unsigned tm,
                                         int unsigned hb, int unsigned msg,
                                         int unsigned cnt);
        slot_result_t r;
        r.admitted       = adm[0];
        r.slot_index     = idx[1:0];
        r.found          = fnd[0];
        r.evicted_valid  = evv[0];
        r.evicted_client = evc[15:0];
        r.timeout_mask   = tm[3:0];
        r.heartbeat_sent = hb[0];
        r.message_number = msg;
        r.active_count   = cnt[2:0];
        return r;
    endfunction

    function automatic dir_row_t row(cst_pkg::op_t op, logic [15:0] cid, logic [31:0] stamp,
                                     bit typed, slot_result_t want);
        dir_row_t d;
        d.op    = op;
        d.cid   = cid;
        d.stamp = stamp;
        d.typed = typed;
        d.want  = want;
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : rsp_monitor
        slot_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transaction", 32'd1, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.admitted !== want.admitted)
                    report_mismatch("admitted", 32'(rsp_ch.admitted),
                                    32'(want.admitted));
                if (rsp_ch.slot_index !== want.slot_index)
                    report_mismatch("slot_index", 32'(rsp_ch.slot_index),
                                    32'(want.slot_index));
                if (rsp_ch.found !== want.found)
                    report_mismatch("found", 32'(rsp_ch.found), 32'(want.found));
                if (rsp_ch.evicted_valid !== want.evicted_valid)
                    report_mismatch("evicted_valid", 32'(rsp_ch.evicted_valid),
                                    32'(want.evicted_valid));
                if (rsp_ch.evicted_client !== want.evicted_client)
                    report_mismatch("evicted_client", 32'(rsp_ch.evicted_client),
                                    32'(want.evicted_client));
                if (rsp_ch.timeout_mask !== want.timeout_mask)
                    report_mismatch("timeout_mask", 32'(rsp_ch.timeout_mask),
                                    32'(want.timeout_mask));
                if (rsp_ch.heartbeat_sent !== want.heartbeat_sent)
                    report_mismatch("heartbeat_sent", 32'(rsp_ch.heartbeat_sent),
                                    32'(want.heartbeat_sent));
                if (rsp_ch.message_number !== want.message_number)
                    report_mismatch("message_number", rsp_ch.message_number,
                                    want.message_number);
                if (rsp_ch.active_count !== want.active_count)
                    report_mismatch("active_count", 32'(rsp_ch.active_count),
                                    32'(want.active_count));
            end
        end
    end

    // stalls the response channel; a hold request gives one long stretch
    initial
    begin : rsp_stall
        int gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (hold_request)
            begin
                gap          = STALL_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("connection_slot_table regression: fail");
        $finish;
    end

    task automatic send_request(cst_pkg::op_t op, logic [15:0] cid, logic [31:0] stamp,
                                bit typed, slot_result_t want);
        int           gap;
        slot_result_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.client_id <= cid;
        req_ch.now       <= stamp;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = slot_table_step(op, cid, stamp);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_table();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(logic [31:0] timeout_val, logic [31:0] interval_val);
        cfg_we    <= 1'b1;
        cfg_index <= cst_pkg::CFG_CLIENT_TIMEOUT;
        cfg_data  <= timeout_val;
        @(negedge clk);
        cfg_index <= cst_pkg::CFG_HEARTBEAT_INTERVAL;
        cfg_data  <= interval_val;
        @(negedge clk);
        cfg_we     <= 1'b0;
        timeout_ms = timeout_val;
        beat_ms    = interval_val;
    endtask

    initial
    begin : stimulus
        dir_row_t     directed_rows [$];
        phase_t       phases [$];
        logic [15:0]  client_pool [POOL_SIZE];
        logic [31:0]  clock_ms;
        logic [15:0]  cid;
        cst_pkg::op_t op;
        int           pick;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = cst_pkg::OP_ADMIT;
        req_ch.client_id = '0;
        req_ch.now       = '0;
        cfg_we           = 1'b0;
        cfg_index        = cst_pkg::CFG_CLIENT_TIMEOUT;
        cfg_data         = '0;
        quiet            = 1'b0;
        hold_request     = 1'b0;
        mismatch_count   = 0;

        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i]   = 1'b0;
            slot_owner[i]  = '0;
            slot_joined[i] = '0;
            slot_seen[i]   = '0;
        end
        last_beat  = '0;
        beat_seq   = '0;
        timeout_ms = cst_pkg::TIMEOUT_RESET;
        beat_ms    = cst_pkg::INTERVAL_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_rows = '{
            row(cst_pkg::OP_ADMIT,      16'h0000, 32'd0,        1'b1,
                res(1, 0, 0, 0, 0, 0, 0, 0, 0)),
            row(cst_pkg::OP_DISCONNECT, 16'hFFFF, 32'd0,        1'b1,
                res(0, 0, 0, 0, 0, 0, 0, 0, 0)),
            row(cst_pkg::OP_TICK,       16'h0000, 32'd0,        1'b1,
                res(0, 0, 0, 0, 0, 0, 0, 0, 0)),
            row(cst_pkg::OP_CONNECT,    16'h0000, 32'd100,      1'b1,
                res(0, 0, 1, 0, 0, 0, 0, 0, 1)),
            row(cst_pkg::OP_CONNECT,    16'hFFFF, 32'hFFFFFFFF, 1'b1,
                res(0, 1, 1, 0, 0, 0, 0, 0, 2)),
            row(cst_pkg::OP_CONNECT,    16'h1234, 32'd50,       1'b0, PREDICT),
            row(cst_pkg::OP_ADMIT,      16'h0000, 32'd60,       1'b0, PREDICT),
            row(cst_pkg::OP_CONNECT,    16'hABCD, 32'd200,      1'b0, PREDICT),
            row(cst_pkg::OP_ADMIT,      16'h0000, 32'd250,      1'b1,
                res(0, 0, 0, 0, 0, 0, 0, 0, 4)),
            row(cst_pkg::OP_CONNECT,    16'h5555, 32'd300,      1'b1,
                res(0, 2, 1, 1, 'h1234, 0, 0, 0, 4)),
            row(cst_pkg::OP_DISCONNECT, 16'hFFFF, 32'd300,      1'b0, PREDICT),
            row(cst_pkg::OP_TICK,       16'h0000, 32'd15000,    1'b0, PREDICT),
            row(cst_pkg::OP_TICK,       16'h0000, 32'd20000,    1'b0, PREDICT),
            row(cst_pkg::OP_TICK,       16'h0000, 32'd80000,    1'b1,
                res(0, 0, 0, 0, 0, 'b1101, 0, 0, 0)),
            row(cst_pkg::OP_TICK,       16'h0000, 32'd100000,   1'b0, PREDICT),
            row(cst_pkg::OP_CONNECT,    16'h0007, 32'hFFFFFF00, 1'b0, PREDICT),
            row(cst_pkg::OP_TICK,       16'h0000, 32'h00000100, 1'b0, PREDICT),
            row(cst_pkg::OP_CONNECT,    16'h0007, 32'h00000200, 1'b0, PREDICT),
            row(cst_pkg::OP_DISCONNECT, 16'h0007, 32'h00000300, 1'b0, PREDICT),
            row(cst_pkg::OP_DISCONNECT, 16'h0007, 32'h00000300, 1'b0, PREDICT),
            row(cst_pkg::OP_DISCONNECT, 16'h0007, 32'h00000300, 1'b0, PREDICT),
            row(cst_pkg::OP_ADMIT,      16'hFFFF, 32'hFFFFFFFF, 1'b0, PREDICT)
        };
        foreach (directed_rows[k])
            send_request(directed_rows[k].op, directed_rows[k].cid,
                         directed_rows[k].stamp, directed_rows[k].typed,
                         directed_rows[k].want);
        drain_table();

        phases = '{
            '{32'd1,         32'd1,         4,    1'b0},
            '{32'hFFFFFFFF,  32'hFFFFFFFF,  3000, 1'b0},
            '{32'd0,         32'd0,         100,  1'b1},
            '{32'd500,       32'd200,       60,   1'b0},
            '{32'd4000,      32'd1000,      300,  1'b0},
            '{32'd2500,      32'hFFFFFFFF,  200,  1'b0},
            '{32'hFFFFFFFF,  32'd1,         50,   1'b1},
            '{32'd0,         32'd0,         400,  1'b0}
        };
        phases[7].timeout_ms  = $urandom_range(100, 5000);
        phases[7].interval_ms = $urandom_range(50, 3000);

        clock_ms = $urandom;
        foreach (phases[p])
        begin
            configure(phases[p].timeout_ms, phases[p].interval_ms);
            quiet = phases[p].quiet;
            for (int i = 0; i < POOL_SIZE; i++)
                client_pool[i] = 16'($urandom_range(0, 65535));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 4 && n == 40)
                    hold_request = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    op = cst_pkg::OP_ADMIT;
                else if (pick < 50)
                    op = cst_pkg::OP_CONNECT;
                else if (pick < 75)
                    op = cst_pkg::OP_DISCONNECT;
                else
                    op = cst_pkg::OP_TICK;
                if ($urandom_range(0, 9) == 0)
                    cid = 16'($urandom_range(0, 65535));
                else
                    cid = client_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 39) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, phases[p].step_ms);
                send_request(op, cid, clock_ms, 1'b0, PREDICT);
            end
            drain_table();
        end

        repeat (DRAIN_CYCLES * 3) @(negedge clk);
        if (mismatch_count == 0)
            $display("connection_slot_table regression: pass");
        else
            $display("connection_slot_table regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/cst_pkg.sv
hdl/cst_if.sv
hdl/cst_ctrl.sv
hdl/cst_datapath.sv
hdl/connection_slot_table.sv
hdl/cst_checker.sv
dv/tb_connection_slot_table.sv
